@@ rtl/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// Stumpff C/S evaluator package
// Shared widths, series constants and the request bundle that flows between
// the series term stages.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int Z_W         = 32;
   localparam int RES_W       = 32;
   localparam int TERM_W      = 64;
   localparam int SERIES      = 2;
   localparam int TERMS       = 28;
   localparam int DIGIT_W     = 12;
   localparam int DIGITS      = 6;
   localparam int QUO_W       = DIGITS * DIGIT_W;
   localparam int DIV_W       = 12;
   localparam int V_W         = DIV_W + DIGIT_W;
   localparam int MAGIC_W     = 33;
   localparam int MAGIC_SHIFT = 36;
   localparam int PROD_W      = V_W + MAGIC_W;
   localparam int OUT_SHIFT   = 25;
   localparam int SHIFTED_W   = TERM_W + 1 - OUT_SHIFT;

   localparam logic [TERM_W-1:0] C_TERM0    = TERM_W'(64'd1 << 47);
   localparam logic [TERM_W-1:0] S_TERM0    = TERM_W'((64'd1 << 48) / 64'd6);
   localparam logic [TERM_W:0]   ROUND_BIAS = (TERM_W + 1)'(65'd1 << (OUT_SHIFT - 1));

   typedef struct packed {
      logic [Z_W-1:0]           mag;
      logic                     alt;
      logic signed [TERM_W-1:0] acc;
   } scs_side_type;

   typedef struct packed {
      logic              valid;
      scs_side_type      side;
      logic [TERM_W-1:0] term;
   } scs_item_type;

endpackage

@@ rtl/scs_term.sv @@
// ----------------------------------------------------------------------------
// Stumpff series term stage
// Adds the incoming term to the running sum (subtracts it on odd terms of an
// alternating series) and forms floor(floor(t * m / 2^24) / d) as the next
// term, dividing one 12-bit digit at a time by reciprocal multiplication.
// ----------------------------------------------------------------------------
module scs_term import scs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  scs_item_type       item_in,
   input  logic               odd_in,
   input  logic [DIV_W-1:0]   divisor_in,
   input  logic [MAGIC_W-1:0] magic_in,
   output scs_item_type       item_out
);

   logic                     a_valid_ff;
   scs_side_type             a_side_ff;
   scs_side_type             a_side_in;
   logic [TERM_W-1:0]        a_hi_ff;
   logic [TERM_W-1:0]        a_lo_ff;
   logic                     b_valid_ff;
   scs_side_type             b_side_ff;
   logic [TERM_W-1:0]        b_x_ff;

   logic                     q_valid_ff [DIGITS];
   scs_side_type             q_side_ff  [DIGITS];
   logic [TERM_W-1:0]        q_x_ff     [DIGITS];
   logic [V_W-1:0]           q_v_ff     [DIGITS];
   logic [DIGIT_W-1:0]       q_q_ff     [DIGITS];
   logic [QUO_W-1:0]         q_quo_ff   [DIGITS];
   logic                     r_valid_ff [DIGITS];
   scs_side_type             r_side_ff  [DIGITS];
   logic [TERM_W-1:0]        r_x_ff     [DIGITS];
   logic [DIV_W-1:0]         r_rem_ff   [DIGITS];
   logic [QUO_W-1:0]         r_quo_ff   [DIGITS];

   always_comb begin
      a_side_in = item_in.side;
      if (item_in.side.alt && odd_in) begin
         a_side_in.acc = item_in.side.acc - signed'(item_in.term);
      end else begin
         a_side_in.acc = item_in.side.acc + signed'(item_in.term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= item_in.valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff <= a_side_in;
      a_hi_ff   <= TERM_W'(item_in.term[TERM_W-1:32]) * TERM_W'(item_in.side.mag);
      a_lo_ff   <= TERM_W'(item_in.term[31:0]) * TERM_W'(item_in.side.mag);
      b_side_ff <= a_side_ff;
      b_x_ff    <= (a_hi_ff << 8) + (a_lo_ff >> 24);
   end

   for (genvar i = 0; i < DIGITS; i++) begin : g_digit
      logic               prev_valid;
      scs_side_type       prev_side;
      logic [TERM_W-1:0]  prev_x;
      logic [DIV_W-1:0]   prev_rem;
      logic [QUO_W-1:0]   prev_quo;
      logic [QUO_W-1:0]   x_ext;
      logic [V_W-1:0]     v_in;
      logic [PROD_W-1:0]  prod;
      logic [V_W-1:0]     rem_full;

      if (i == 0) begin : g_first
         assign prev_valid = b_valid_ff;
         assign prev_side  = b_side_ff;
         assign prev_x     = b_x_ff;
         assign prev_rem   = '0;
         assign prev_quo   = '0;
      end else begin : g_next
         assign prev_valid = r_valid_ff[i-1];
         assign prev_side  = r_side_ff[i-1];
         assign prev_x     = r_x_ff[i-1];
         assign prev_rem   = r_rem_ff[i-1];
         assign prev_quo   = r_quo_ff[i-1];
      end

      assign x_ext    = QUO_W'(prev_x);
      assign v_in     = {prev_rem, x_ext[QUO_W-1-i*DIGIT_W -: DIGIT_W]};
      assign prod     = PROD_W'(v_in) * PROD_W'(magic_in);
      assign rem_full = q_v_ff[i] - V_W'(q_q_ff[i]) * V_W'(divisor_in);

      always_ff @(posedge clock) begin
         if (reset) begin
            q_valid_ff[i] <= 1'b0;
            r_valid_ff[i] <= 1'b0;
         end else begin
            q_valid_ff[i] <= prev_valid;
            r_valid_ff[i] <= q_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         q_side_ff[i] <= prev_side;
         q_x_ff[i]    <= prev_x;
         q_v_ff[i]    <= v_in;
         q_q_ff[i]    <= prod[MAGIC_SHIFT +: DIGIT_W];
         q_quo_ff[i]  <= prev_quo;
         r_side_ff[i] <= q_side_ff[i];
         r_x_ff[i]    <= q_x_ff[i];
         r_rem_ff[i]  <= rem_full[DIV_W-1:0];
         r_quo_ff[i]  <= {q_quo_ff[i][QUO_W-DIGIT_W-1:0], q_q_ff[i]};
      end
   end

   assign item_out.valid = r_valid_ff[DIGITS-1];
   assign item_out.side  = r_side_ff[DIGITS-1];
   assign item_out.term  = r_quo_ff[DIGITS-1][TERM_W-1:0];

endmodule

@@ rtl/stumpff_c_s_evaluator.sv @@
// ----------------------------------------------------------------------------
// Stumpff C/S evaluator
// Returns the Stumpff functions C(z) and S(z) of a signed Q8.24 argument as
// unsigned Q9.23 values, by summing 28 terms of their power series.
// ----------------------------------------------------------------------------
// A request is taken at a rising clock edge where start is high and busy is
// low. The block never raises busy, so a new request can be issued in every
// cycle. The request carries req_z_value.
// Each request produces one response: rsp_strobe is high for exactly one
// cycle while rsp_c_result and rsp_s_result hold C(z) and S(z). The receiver
// cannot stall the block, and responses leave in request order.
// From the accepting edge, a request passes through the 27 series term stages,
// each with a product register, an align register and six digit steps of the
// constant divider (a quotient and a remainder register each), and then
// through the final sum and rounding registers. Throughput is one request per
// cycle. Both series run in parallel pipelines of equal depth.
// Reset clears all valid bits, so no strobe appears from requests that were
// in flight when reset was applied.
// ----------------------------------------------------------------------------
module stumpff_c_s_evaluator import scs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [Z_W-1:0]   req_z_value,
   output logic                    rsp_strobe,
   output logic [RES_W-1:0]        rsp_c_result,
   output logic [RES_W-1:0]        rsp_s_result
);

   logic [Z_W-1:0]           raw;
   logic [Z_W-1:0]           mag;
   logic                     alt;
   logic                     accept;
   scs_item_type             chain      [SERIES][TERMS];
   logic                     f_valid_ff [SERIES];
   logic signed [TERM_W-1:0] f_acc_ff   [SERIES];
   logic [RES_W-1:0]         res_ff     [SERIES];
   logic                     rsp_strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign raw    = req_z_value;
   assign mag    = raw[Z_W-1] ? (~raw + Z_W'(1)) : raw;
   assign alt    = !raw[Z_W-1] && (raw != '0);

   for (genvar j = 0; j < SERIES; j++) begin : g_series
      logic signed [TERM_W-1:0] f_acc_in;
      logic [TERM_W:0]          rounded;
      logic [SHIFTED_W-1:0]     shifted;
      logic [RES_W-1:0]         res_in;

      assign chain[j][0].valid    = accept;
      assign chain[j][0].side.mag = mag;
      assign chain[j][0].side.alt = alt;
      assign chain[j][0].side.acc = '0;
      assign chain[j][0].term     = (j == 0) ? C_TERM0 : S_TERM0;

      for (genvar k = 1; k < TERMS; k++) begin : g_term
         localparam int          D     = (2 * k + 1 + j) * (2 * k + 2 + j);
         localparam int          ODD   = (k - 1) % 2;
         localparam logic [63:0] MAGIC =
            ((64'd1 << MAGIC_SHIFT) + 64'(D) - 64'd1) / 64'(D);

         scs_term u_term (
            .clock      (clock),
            .reset      (reset),
            .item_in    (chain[j][k-1]),
            .odd_in     (1'(ODD)),
            .divisor_in (DIV_W'(D)),
            .magic_in   (MAGIC[MAGIC_W-1:0]),
            .item_out   (chain[j][k])
         );
      end

      always_comb begin
         if (chain[j][TERMS-1].side.alt) begin
            f_acc_in = chain[j][TERMS-1].side.acc - signed'(chain[j][TERMS-1].term);
         end else begin
            f_acc_in = chain[j][TERMS-1].side.acc + signed'(chain[j][TERMS-1].term);
         end
      end

      assign rounded = {1'b0, f_acc_ff[j]} + ROUND_BIAS;
      assign shifted = rounded[TERM_W:OUT_SHIFT];

      always_comb begin
         if (f_acc_ff[j][TERM_W-1]) begin
            res_in = '0;
         end else if (|shifted[SHIFTED_W-1:RES_W]) begin
            res_in = '1;
         end else begin
            res_in = shifted[RES_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            f_valid_ff[j] <= 1'b0;
         end else begin
            f_valid_ff[j] <= chain[j][TERMS-1].valid;
         end
      end

      always_ff @(posedge clock) begin
         f_acc_ff[j] <= f_acc_in;
         res_ff[j]   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= f_valid_ff[0] && f_valid_ff[1];
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_c_result = res_ff[0];
   assign rsp_s_result = res_ff[1];

   // Both series pipelines must carry the same requests in lockstep.
   assert property (@(posedge clock) disable iff (reset)
      chain[0][TERMS-1].valid == chain[1][TERMS-1].valid)
      else $error("series pipelines out of step");

   assert property (@(posedge clock) disable iff (reset)
      f_valid_ff[0] == f_valid_ff[1])
      else $error("final sum stages out of step");

   // A cycle of reset leaves no response behind it.
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_strobe)
      else $error("response strobe right after reset");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stumpff C/S evaluator testbench
// Drives signed Q8.24 arguments into the evaluator with random gaps, predicts
// C(z) and S(z) with a bit-exact power-series model, and compares each
// response strobe against the oldest predicted pair.
// ----------------------------------------------------------------------------
module testbench;
   import scs_pkg::*;

   localparam int LATENCY   = 380;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 1500;

   typedef struct packed {
      logic [RES_W-1:0] c_val;
      logic [RES_W-1:0] s_val;
   } cs_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic signed [Z_W-1:0] req_z_value = '0;
   logic                  rsp_strobe;
   logic [RES_W-1:0]      rsp_c_result;
   logic [RES_W-1:0]      rsp_s_result;

   logic [Z_W-1:0] pending_args[$];
   int             gap_lens[$];
   cs_pair_type    expected_pairs[$];
   int             error_count = 0;
   int             sent_count = 0;
   int             recv_count = 0;
   int             idle_cycles = 0;
   int             gap_left = 0;
   bit             hold_for_drain = 1'b0;
   int             drain_at = -1;

   stumpff_c_s_evaluator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_z_value(req_z_value), .rsp_strobe(rsp_strobe),
      .rsp_c_result(rsp_c_result), .rsp_s_result(rsp_s_result)
   );

   always #5 clock = ~clock;

   function automatic logic [RES_W-1:0] series_sum(logic [63:0] first, int offset,
                                                   logic [63:0] mag, bit alternate);
      logic [63:0] term;
      logic [63:0] prod;
      logic [63:0] div;
      logic [63:0] rounded;
      logic signed [63:0] acc;
      term = first;
      acc  = first;
      for (int k = 1; k < TERMS; k++) begin
         div  = 64'(2 * k + offset);
         prod = (((term >> 32) * mag) << 8) + (((term & 64'hFFFF_FFFF) * mag) >> 24);
         term = prod / (div * (div + 64'd1));
         if (alternate && k[0]) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) return '0;
      rounded = (acc + (64'd1 << 24)) >> 25;
      if (rounded > 64'hFFFF_FFFF) return '1;
      return rounded[31:0];
   endfunction

   function automatic cs_pair_type stumpff_pair(logic [Z_W-1:0] z);
      cs_pair_type pair;
      logic [63:0] mag;
      logic [Z_W-1:0] neg_z;
      bit positive;
      positive = !z[31] && z != 0;
      neg_z = ~z + Z_W'(1);
      mag = z[31] ? 64'(neg_z) : 64'(z);
      pair.c_val = series_sum(C_TERM0, 1, mag, positive);
      pair.s_val = series_sum(S_TERM0, 2, mag, positive);
      return pair;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Requests change on the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sent_count <= sent_count + 1;
         end
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (hold_for_drain && (expected_pairs.size() != 0 || start)) begin
            start <= 1'b0;
         end else if (pending_args.size() != 0 && !(start && busy)) begin
            if (sent_count == drain_at) begin
               hold_for_drain <= 1'b1;
               drain_at <= -1;
               start <= 1'b0;
            end else begin
               hold_for_drain <= 1'b0;
               start <= 1'b1;
               req_z_value <= pending_args.pop_front();
               gap_left <= gap_lens.pop_front();
            end
         end else if (!(start && busy)) begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (start && !busy) begin
            expected_pairs.push_back(stumpff_pair(req_z_value));
         end
         if (rsp_strobe) begin
            recv_count = recv_count + 1;
            if (expected_pairs.size() == 0) begin
               $error("unexpected response c=%h s=%h", rsp_c_result, rsp_s_result);
               error_count = error_count + 1;
            end else begin
               cs_pair_type want;
               want = expected_pairs.pop_front();
               if (rsp_c_result !== want.c_val) begin
                  $error("c_result expected %h actual %h", want.c_val, rsp_c_result);
                  error_count = error_count + 1;
               end
               if (rsp_s_result !== want.s_val) begin
                  $error("s_result expected %h actual %h", want.s_val, rsp_s_result);
                  error_count = error_count + 1;
               end
            end
         end
         if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic [Z_W-1:0] directed[$];
      logic [Z_W-1:0] z;
      directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0001, 32'h0100_0000, 32'hFF00_0000,
                   32'h0400_0000, 32'hFC00_0000, 32'h09DE_9E64, 32'h277A_6C30,
                   32'h5000_0000, 32'hB000_0000, 32'h0000_1000, 32'hFFFF_F000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000, 32'hC000_0000};
      foreach (directed[i]) begin
         pending_args.push_back(directed[i]);
         gap_lens.push_back(i < 10 ? 0 : pick_gap());
      end
      drain_at = directed.size();
      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 3))
            0: z = $urandom();
            1: z = Z_W'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
            2: z = Z_W'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
            default: z = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
         endcase
         pending_args.push_back(z);
         gap_lens.push_back((i > 400 && i < 700) ? 0 : pick_gap());
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_args.size() == 0 && !start);
      wait (expected_pairs.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d arguments (%0d directed) and checked %0d C/S responses.",
               sent_count, directed.size(), recv_count);
      $display("Coverage: zero, both signs, full-scale extremes, small and large |z|.");
      if (error_count == 0 && expected_pairs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
